[rtl/core/text_console_writer_core_assert.svh]
// assertion macros for the text console writer core
`ifndef TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define TCW_ASSERT_SAME(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define TCW_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

[rtl/core/tcw_pkg.sv]
// package of types and constants for the text console writer
`timescale 1ns / 1ps

package tcw_pkg;

    // default screen geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // request kinds
    localparam logic [1:0] KIND_PUT   = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // character codes and attribute
    localparam logic [7:0] NEWLINE_CODE    = 8'd10;
    localparam logic [7:0] SPACE_CODE      = 8'd32;
    localparam logic [7:0] RESET_ATTRIBUTE = 8'd15;

    // configuration port
    localparam int         APB_ADDR_W       = 3;
    localparam int         APB_DATA_W       = 32;
    localparam logic       REG_DEFAULT_ATTR = 1'b0;

    // sequencer states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_FILL,
        ST_READ,
        ST_SCROLL,
        ST_DONE
    } tcw_state_t;

endpackage

[rtl/core/tcw_if.sv]
// request and result channel interfaces of the text console writer
`timescale 1ns / 1ps

interface tcw_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] char_code;
    logic [7:0] attribute;
    logic       use_cursor;
    logic [6:0] column;
    logic [4:0] line;

    modport source (output valid, kind, char_code, attribute, use_cursor, column, line,
                    input ready);
    modport sink   (input valid, kind, char_code, attribute, use_cursor, column, line,
                    output ready);
endinterface

interface tcw_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] cursor_column;
    logic [4:0] cursor_line;
    logic [7:0] cell_char;
    logic [7:0] cell_attribute;
    logic       scrolled;

    modport source (output valid, cursor_column, cursor_line, cell_char, cell_attribute,
                    scrolled, input ready);
    modport sink   (input valid, cursor_column, cursor_line, cell_char, cell_attribute,
                    scrolled, output ready);
endinterface

[rtl/core/tcw_ram.sv]
// screen store: one write port, one read port with registered data
`timescale 1ns / 1ps

module tcw_ram #(
    parameter int   DEPTH = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF,
    parameter int   WIDTH = 16,
    localparam int  AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/tcw_apb.sv]
// configuration register file behind the apb port
`timescale 1ns / 1ps

module tcw_apb (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tcw_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [tcw_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [tcw_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output logic [7:0]                      default_attr
);

    logic [7:0] default_attr_reg;
    logic [7:0] default_attr_next;
    logic       reg_hit;

    // register index decode
    assign reg_hit = (paddr[2] == tcw_pkg::REG_DEFAULT_ATTR);

    // write on the access phase
    always_comb
    begin
        default_attr_next = default_attr_reg;
        if (psel && penable && pwrite && reg_hit)
        begin
            default_attr_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_attr_reg <= tcw_pkg::RESET_ATTRIBUTE;
        end
        else
        begin
            default_attr_reg <= default_attr_next;
        end
    end

    // read back
    assign prdata       = reg_hit ? {24'd0, default_attr_reg} : '0;
    assign pready       = 1'b1;
    assign default_attr = default_attr_reg;

endmodule

[rtl/core/text_console_writer_core.sv]
// top level of the text console writer: sequencer, cursor and result register
`timescale 1ns / 1ps

// Character-cell text console of COLUMNS x ROWS cells held in one single-port-write,
// registered-read memory, with the cursor kept as column and row. After reset the
// block clears the screen store to zero with a pass over all COLUMNS*ROWS cells
// and takes no request meanwhile; configuration writes are taken throughout.
// A put that does not scroll goes through DONE back to IDLE, a cell read through
// READ and DONE; a clear sweeps every cell of the store in FILL and a put that
// scrolls copies the store one cell a cycle in SCROLL, both paced by the single
// memory write port. One request is in work at a time; a finished result waits
// in the output register while the next request is accepted.

`include "text_console_writer_core_assert.svh"

module text_console_writer_core #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    tcw_in_if.sink                          in_ch,
    tcw_out_if.source                       out_ch,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tcw_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [tcw_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [tcw_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int CELL_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);

    tcw_pkg::tcw_state_t state_reg;
    tcw_pkg::tcw_state_t state_next;

    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [COL_W-1:0]  cur_col_reg;
    logic [COL_W-1:0]  cur_col_next;
    logic [ROW_W-1:0]  cur_row_reg;
    logic [ROW_W-1:0]  cur_row_next;
    logic [15:0]       fill_data_reg;
    logic [15:0]       fill_data_next;
    logic [7:0]        res_char_reg;
    logic [7:0]        res_char_next;
    logic [7:0]        res_attr_reg;
    logic [7:0]        res_attr_next;
    logic              res_scrolled_reg;
    logic              res_scrolled_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [6:0]        out_col_reg;
    logic [4:0]        out_row_reg;
    logic [7:0]        out_char_reg;
    logic [7:0]        out_attr_reg;
    logic              out_scrolled_reg;

    logic [7:0]        default_attr;
    logic              accept;
    logic              out_load;
    logic              col_ok;
    logic              row_ok;
    logic              use_tgt;
    logic [COL_W-1:0]  tgt_col;
    logic [ROW_W-1:0]  tgt_row;
    logic [CELL_W-1:0] tgt_addr;
    logic [7:0]        attr_eff;
    logic              is_nl;
    logic              row_end;
    logic              last_row;
    logic              wrap;
    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]  copy_src;
    logic              copy_rd;
    logic              copy_keep;

    logic              mem_we;
    logic [CELL_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic [CELL_W-1:0] mem_raddr;
    logic [15:0]       mem_rdata;

    // configuration registers
    tcw_apb u_apb (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .default_attr (default_attr)
    );

    // screen store
    tcw_ram #(
        .DEPTH (CELLS),
        .WIDTH (16)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // handshakes
    assign accept   = in_ch.valid && in_ch.ready;
    assign out_load = (state_reg == tcw_pkg::ST_DONE) && (!out_valid_reg || out_ch.ready);

    // target cell: explicit position when in range, cursor otherwise
    assign col_ok   = {1'b0, in_ch.column} < 8'(COLUMNS);
    assign row_ok   = {1'b0, in_ch.line} < 6'(ROWS);
    assign use_tgt  = !in_ch.use_cursor && col_ok && row_ok;
    assign tgt_col  = use_tgt ? in_ch.column[COL_W-1:0] : cur_col_reg;
    assign tgt_row  = use_tgt ? in_ch.line[ROW_W-1:0] : cur_row_reg;
    assign tgt_addr = CELL_W'(tgt_row) * CELL_W'(COLUMNS) + CELL_W'(tgt_col);

    // put: attribute choice and cursor advance
    assign attr_eff = (in_ch.attribute == 8'd0) ? default_attr : in_ch.attribute;
    assign is_nl    = (in_ch.char_code == tcw_pkg::NEWLINE_CODE);
    assign row_end  = is_nl || (tgt_col == COL_W'(COLUMNS - 1));
    assign last_row = (tgt_row == ROW_W'(ROWS - 1));
    assign wrap     = row_end && last_row;

    // scroll pass: read cell s+COLUMNS, write cell s-1 from the previous read, or zero in the last row
    assign cnt_m1    = cnt_reg - CNT_W'(1);
    assign copy_rd   = cnt_reg < CNT_W'(CELLS - COLUMNS);
    assign copy_src  = copy_rd ? (cnt_reg + CNT_W'(COLUMNS)) : '0;
    assign copy_keep = cnt_m1 < CNT_W'(CELLS - COLUMNS);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tcw_pkg::ST_INIT:
            begin
                if (cnt_reg == CNT_W'(CELLS - 1))
                begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_ch.kind)
                        tcw_pkg::KIND_PUT:   state_next = wrap ? tcw_pkg::ST_SCROLL
                                                               : tcw_pkg::ST_DONE;
                        tcw_pkg::KIND_CLEAR: state_next = tcw_pkg::ST_FILL;
                        tcw_pkg::KIND_READ:  state_next = tcw_pkg::ST_READ;
                        default:             state_next = tcw_pkg::ST_DONE;
                    endcase
                end
            end
            tcw_pkg::ST_FILL:
            begin
                if (cnt_reg == CNT_W'(CELLS - 1))
                begin
                    state_next = tcw_pkg::ST_DONE;
                end
            end
            tcw_pkg::ST_READ:
            begin
                state_next = tcw_pkg::ST_DONE;
            end
            tcw_pkg::ST_SCROLL:
            begin
                if (cnt_reg == CNT_W'(CELLS))
                begin
                    state_next = tcw_pkg::ST_DONE;
                end
            end
            tcw_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tcw_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        in_ch.ready       = 1'b0;
        mem_we            = 1'b0;
        mem_waddr         = '0;
        mem_wdata         = '0;
        mem_raddr         = '0;
        cnt_next          = cnt_reg;
        cur_col_next      = cur_col_reg;
        cur_row_next      = cur_row_reg;
        fill_data_next    = fill_data_reg;
        res_char_next     = res_char_reg;
        res_attr_next     = res_attr_reg;
        res_scrolled_next = res_scrolled_reg;
        case (state_reg)
            tcw_pkg::ST_INIT,
            tcw_pkg::ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg[CELL_W-1:0];
                mem_wdata = fill_data_reg;
                cnt_next  = (cnt_reg == CNT_W'(CELLS - 1)) ? '0 : cnt_reg + CNT_W'(1);
            end
            tcw_pkg::ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                mem_raddr   = tgt_addr;
                if (accept)
                begin
                    res_char_next     = 8'd0;
                    res_attr_next     = 8'd0;
                    res_scrolled_next = 1'b0;
                    case (in_ch.kind)
                        tcw_pkg::KIND_PUT:
                        begin
                            mem_we            = !is_nl;
                            mem_waddr         = tgt_addr;
                            mem_wdata         = {attr_eff, in_ch.char_code};
                            res_scrolled_next = wrap;
                            cur_col_next      = row_end ? '0 : tgt_col + COL_W'(1);
                            if (wrap)
                            begin
                                cur_row_next = ROW_W'(ROWS - 1);
                            end
                            else if (row_end)
                            begin
                                cur_row_next = tgt_row + ROW_W'(1);
                            end
                            else
                            begin
                                cur_row_next = tgt_row;
                            end
                        end
                        tcw_pkg::KIND_CLEAR:
                        begin
                            fill_data_next = {default_attr, tcw_pkg::SPACE_CODE};
                            cur_col_next   = '0;
                            cur_row_next   = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            tcw_pkg::ST_READ:
            begin
                res_char_next = mem_rdata[7:0];
                res_attr_next = mem_rdata[15:8];
            end
            tcw_pkg::ST_SCROLL:
            begin
                mem_raddr = copy_src[CELL_W-1:0];
                mem_we    = (cnt_reg != '0);
                mem_waddr = cnt_m1[CELL_W-1:0];
                mem_wdata = copy_keep ? mem_rdata : 16'd0;
                cnt_next  = (cnt_reg == CNT_W'(CELLS)) ? '0 : cnt_reg + CNT_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    // result register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcw_pkg::ST_INIT;
            cnt_reg       <= '0;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            fill_data_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            fill_data_reg <= fill_data_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        res_char_reg     <= res_char_next;
        res_attr_reg     <= res_attr_next;
        res_scrolled_reg <= res_scrolled_next;
        if (out_load)
        begin
            out_col_reg      <= 7'(cur_col_reg);
            out_row_reg      <= 5'(cur_row_reg);
            out_char_reg     <= res_char_reg;
            out_attr_reg     <= res_attr_reg;
            out_scrolled_reg <= res_scrolled_reg;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.cursor_column  = out_col_reg;
    assign out_ch.cursor_line    = out_row_reg;
    assign out_ch.cell_char      = out_char_reg;
    assign out_ch.cell_attribute = out_attr_reg;
    assign out_ch.scrolled       = out_scrolled_reg;

    // checks
    `TCW_ASSERT_SAME(a_cursor_range, clk, rst_n, state_reg == tcw_pkg::ST_IDLE,
        (cur_col_reg < COL_W'(COLUMNS - 1) || cur_col_reg == COL_W'(COLUMNS - 1)) &&
        (cur_row_reg < ROW_W'(ROWS - 1) || cur_row_reg == ROW_W'(ROWS - 1)),
        "cursor outside the screen")
    `TCW_ASSERT_SAME(a_scroll_cursor, clk, rst_n,
        state_reg == tcw_pkg::ST_DONE && res_scrolled_reg,
        cur_col_reg == '0 && cur_row_reg == ROW_W'(ROWS - 1),
        "scroll left the cursor off the last row start")
    `TCW_ASSERT_NEXT(a_clear_fill, clk, rst_n,
        accept && in_ch.kind == tcw_pkg::KIND_CLEAR,
        state_reg == tcw_pkg::ST_FILL && cnt_reg == '0,
        "clear request did not start a fill pass")

endmodule
